[hdl/xtea_ctr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// XTEA counter-mode page cipher package
// Shared item types, register indexes and round constants.
// ----------------------------------------------------------------------------
package xtea_ctr_pkg;

  // Field widths fixed by the item format.
  localparam int unsigned WordW     = 32;
  localparam int unsigned BlockIdxW = 9;
  localparam int unsigned CfgIdxW   = 3;

  // Default number of XTEA rounds.
  localparam int unsigned NumRounds = 32;

  // XTEA round constant.
  localparam logic [WordW-1:0] XteaDelta = 32'h9E37_79B9;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CfgKeyWord0   = 3'd0,
    CfgKeyWord1   = 3'd1,
    CfgKeyWord2   = 3'd2,
    CfgKeyWord3   = 3'd3,
    CfgCryptEnable = 3'd4
  } cfg_idx_e;

  // Input item.
  typedef struct packed {
    logic [WordW-1:0]     page_number;
    logic [BlockIdxW-1:0] block_index;
    logic [WordW-1:0]     data_low;
    logic [WordW-1:0]     data_high;
  } xtea_in_t;

  // Result item.
  typedef struct packed {
    logic [WordW-1:0] out_low;
    logic [WordW-1:0] out_high;
  } xtea_out_t;

  // Data carried from cell to cell: the two cipher words and the data words.
  typedef struct packed {
    logic [WordW-1:0] word_a;
    logic [WordW-1:0] word_b;
    logic [WordW-1:0] data_low;
    logic [WordW-1:0] data_high;
  } cell_data_t;

  // Running sum after r rounds, evaluated at elaboration.
  function automatic logic [WordW-1:0] round_sum(input int unsigned r);
    logic [63:0] prod;
    prod = 64'(r) * 64'(XteaDelta);
    return prod[WordW-1:0];
  endfunction

endpackage

[hdl/xtea_counter_mode_page_cipher_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// XTEA counter-mode page cipher unit
// Enciphers the counter block of each 8-byte page block and XORs the
// keystream onto the data words.
// ----------------------------------------------------------------------------
// The unit takes one item per clock cycle while the output is not
// stalled. Every item passes through a row of 2*ROUNDS half-round
// cells, each with its own register and valid flag, so a stall at the
// output fills empty stages before it holds the input. With
// crypt_enable clear the data words come out unchanged through the same
// cells. The key registers are read directly by the cells and the
// enable register at the output, so all of them must only be written
// while no item is in flight.
// ----------------------------------------------------------------------------
module xtea_counter_mode_page_cipher_unit
  import xtea_ctr_pkg::*;
#(
  parameter int unsigned ROUNDS = NumRounds
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Configuration write port.
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [WordW-1:0]   cfg_wdata_i,
  // Input items.
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  xtea_in_t           in_data_i,
  // Result items.
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output xtea_out_t          out_data_o
);

  localparam int unsigned NumCells = 2 * ROUNDS;

  logic [WordW-1:0] key_q [4];
  logic             enable_q;

  logic       valid_c [NumCells+1];
  logic       ready_c [NumCells+1];
  cell_data_t data_c  [NumCells+1];

  // Configuration register writes; unknown indexes are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q[0] <= '0;
      key_q[1] <= '0;
      key_q[2] <= '0;
      key_q[3] <= '0;
      enable_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgKeyWord0:    key_q[0] <= cfg_wdata_i;
        CfgKeyWord1:    key_q[1] <= cfg_wdata_i;
        CfgKeyWord2:    key_q[2] <= cfg_wdata_i;
        CfgKeyWord3:    key_q[3] <= cfg_wdata_i;
        CfgCryptEnable: enable_q <= cfg_wdata_i[0];
        default:        ;
      endcase
    end
  end

  // Counter block enters the first cell together with the data words.
  assign valid_c[0]          = in_valid_i;
  assign in_ready_o          = ready_c[0];
  assign data_c[0].word_a    = in_data_i.page_number;
  assign data_c[0].word_b    = WordW'(in_data_i.block_index);
  assign data_c[0].data_low  = in_data_i.data_low;
  assign data_c[0].data_high = in_data_i.data_high;

  // Row of half-round cells; sums and key selections are fixed per cell.
  for (genvar n = 0; n < NumCells; n++) begin : g_cell
    localparam bit               UpdHigh = (n % 2) == 1;
    localparam logic [WordW-1:0] CellSum = round_sum((n + 1) / 2);
    localparam logic [1:0]       KeySel  = UpdHigh ? CellSum[12:11] : CellSum[1:0];

    xtea_ctr_cell #(
      .Sum     (CellSum),
      .UpdHigh (UpdHigh)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid_c[n]),
      .ready_o (ready_c[n]),
      .data_i  (data_c[n]),
      .key_i   (key_q[KeySel]),
      .valid_o (valid_c[n+1]),
      .ready_i (ready_c[n+1]),
      .data_o  (data_c[n+1])
    );
  end

  // The last cell's register is the output register; apply the keystream.
  assign out_valid_o         = valid_c[NumCells];
  assign ready_c[NumCells]   = out_ready_i;
  assign out_data_o.out_low  = data_c[NumCells].data_low ^
                               (enable_q ? data_c[NumCells].word_a : '0);
  assign out_data_o.out_high = data_c[NumCells].data_high ^
                               (enable_q ? data_c[NumCells].word_b : '0);

endmodule

[hdl/xtea_ctr_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// XTEA counter-mode half-round cell
// One half of an XTEA round with its own stage register and handshake.
// ----------------------------------------------------------------------------
module xtea_ctr_cell
  import xtea_ctr_pkg::*;
#(
  parameter logic [WordW-1:0] Sum     = '0,
  parameter bit               UpdHigh = 1'b0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  cell_data_t       data_i,
  input  logic [WordW-1:0] key_i,
  output logic             valid_o,
  input  logic             ready_i,
  output cell_data_t       data_o
);

  logic             valid_q;
  cell_data_t       data_q, data_d;
  logic [WordW-1:0] mix_src;
  logic [WordW-1:0] mix;
  logic [WordW-1:0] round_key;
  logic [WordW-1:0] delta;
  logic             load;

  // The stage takes a new item when empty or when its own item moves on.
  assign ready_o = !valid_q || ready_i;
  assign load    = valid_i && ready_o;

  // Half-round: mix one word and add it onto the other.
  always_comb begin
    mix_src   = UpdHigh ? data_i.word_a : data_i.word_b;
    mix       = ((mix_src << 4) ^ (mix_src >> 5)) + mix_src;
    round_key = Sum + key_i;
    delta     = mix ^ round_key;
    data_d    = data_i;
    if (UpdHigh) begin
      data_d.word_b = data_i.word_b + delta;
    end else begin
      data_d.word_a = data_i.word_a + delta;
    end
  end

  // Stage valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // Stage payload.
  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule
